### rtl/core/bcrl_pkg.sv
// ----------------------------------------------------------------------------
// bcrl_pkg
// Shared types and constants for the byte credit request limiter: field
// widths, wait queue sizing, result codes, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package bcrl_pkg;

   localparam int QUEUE_DEPTH   = 16;
   localparam int TAG_BITS      = 8;
   localparam int LIMIT_BITS    = 40;
   localparam int MINCHG_BITS   = 17;
   localparam int LEN_BITS      = 32;
   localparam int CSR_DATA_BITS = 40;
   localparam int CSR_IDX_BITS  = 1;
   localparam int MAX_RESULTS   = QUEUE_DEPTH + 1;
   localparam int QPTR_BITS     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_BITS     = $clog2(QUEUE_DEPTH + 1);
   localparam int RES_BITS      = $clog2(MAX_RESULTS + 1);

   localparam logic [LIMIT_BITS-1:0]  BYTE_LIMIT_RESET = LIMIT_BITS'(1048576);
   localparam logic [MINCHG_BITS-1:0] MIN_CHARGE_RESET = MINCHG_BITS'(4096);

   localparam logic [CSR_IDX_BITS-1:0] CSR_BYTE_LIMIT = CSR_IDX_BITS'(0);
   localparam logic [CSR_IDX_BITS-1:0] CSR_MIN_CHARGE = CSR_IDX_BITS'(1);

   localparam logic KIND_SEND = 1'b0;
   localparam logic KIND_ACK  = 1'b1;

   typedef enum logic [1:0] {
      RES_GRANTED   = 2'd0,
      RES_REJECTED  = 2'd1,
      RES_UNDERFLOW = 2'd2
   } res_status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_DRAIN,
      ST_FLUSH
   } ctrl_state_type;

   typedef struct packed {
      logic in_load;
      logic send_grant;
      logic send_reject;
      logic send_queue;
      logic ack_apply;
      logic drain_grant;
      logic emit_last;
   } ctrl_cmd_type;

   typedef struct packed {
      logic                 is_ack;
      logic                 send_fit;
      logic                 queue_full;
      logic                 head_go;
      logic                 stg_valid;
      logic                 out_free;
      logic [QCNT_BITS-1:0] queue_count;
   } dp_status_type;

endpackage

### rtl/core/bcrl_ctrl.sv
// ----------------------------------------------------------------------------
// bcrl_ctrl
// Sequencer for the limiter: takes one item, runs the send or ack step, walks
// the queue one grant per cycle while output is free, hands off final result
// ----------------------------------------------------------------------------
module bcrl_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  bcrl_pkg::dp_status_type sts,
   output bcrl_pkg::ctrl_cmd_type  cmd
);
   import bcrl_pkg::*;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (sts.is_ack) begin
               state_in = ST_DRAIN;
            end else begin
               state_in = ST_FLUSH;
            end
         end
         ST_DRAIN: begin
            if (!sts.head_go) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (!sts.stg_valid || sts.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.in_load = req_valid;
         end
         ST_EXEC: begin
            if (sts.is_ack) begin
               cmd.ack_apply = 1'b1;
            end else begin
               priority if (sts.send_fit) begin
                  cmd.send_grant = 1'b1;
               end else if (sts.queue_full) begin
                  cmd.send_reject = 1'b1;
               end else begin
                  cmd.send_queue = 1'b1;
               end
            end
         end
         ST_DRAIN: begin
            cmd.drain_grant = sts.head_go && (!sts.stg_valid || sts.out_free);
         end
         ST_FLUSH: begin
            cmd.emit_last = sts.stg_valid && sts.out_free;
         end
         default: cmd = '0;
      endcase
   end

endmodule

### rtl/core/bcrl_dpath.sv
// ----------------------------------------------------------------------------
// bcrl_dpath
// Datapath for the limiter: settings, outstanding byte count, wait queue,
// one staged result whose last flag is still open, and the output register.
// ----------------------------------------------------------------------------
module bcrl_dpath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wen,
   input  logic [bcrl_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [bcrl_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   input  logic                                 req_kind,
   input  logic [bcrl_pkg::LEN_BITS-1:0]        req_request_length,
   input  logic [bcrl_pkg::TAG_BITS-1:0]        req_request_tag,
   input  logic [bcrl_pkg::LEN_BITS-1:0]        req_acked_charge,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [1:0]                           rsp_status,
   output logic [bcrl_pkg::TAG_BITS-1:0]        rsp_granted_tag,
   output logic [bcrl_pkg::LEN_BITS-1:0]        rsp_charge,
   output logic                                 rsp_last,
   input  bcrl_pkg::ctrl_cmd_type               cmd,
   output bcrl_pkg::dp_status_type              sts
);
   import bcrl_pkg::*;

   // settings
   logic [LIMIT_BITS-1:0]  byte_limit_ff;
   logic [MINCHG_BITS-1:0] min_charge_ff;

   // latched item
   logic                kind_ff;
   logic [LEN_BITS-1:0] len_ff;
   logic [TAG_BITS-1:0] tag_ff;
   logic [LEN_BITS-1:0] ack_ff;

   // credit and queue state
   logic [LIMIT_BITS-1:0] outstanding_ff, outstanding_in;
   logic [TAG_BITS-1:0]   q_tag_ff [QUEUE_DEPTH];
   logic [LEN_BITS-1:0]   q_chg_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]  head_ff, head_in;
   logic [QPTR_BITS-1:0]  tail_ff, tail_in;
   logic [QCNT_BITS-1:0]  count_ff, count_in;
   logic [RES_BITS-1:0]   nres_ff, nres_in;

   // staged result
   logic                  stg_valid_ff, stg_valid_in;
   res_status_type        stg_status_ff, stg_status_in;
   logic [TAG_BITS-1:0]   stg_tag_ff, stg_tag_in;
   logic [LEN_BITS-1:0]   stg_chg_ff, stg_chg_in;

   // output register
   logic                  rsp_valid_ff, rsp_valid_in;
   res_status_type        rsp_status_ff;
   logic [TAG_BITS-1:0]   rsp_tag_ff;
   logic [LEN_BITS-1:0]   rsp_chg_ff;
   logic                  rsp_last_ff;
   logic                  rsp_load;
   logic                  rsp_load_last;

   logic [LEN_BITS-1:0]     send_chg;
   logic [LIMIT_BITS:0]     send_sum;
   logic                    send_fits;
   logic [LEN_BITS-1:0]     head_chg;
   logic [TAG_BITS-1:0]     head_tag;
   logic [LIMIT_BITS:0]     head_sum;
   logic                    head_fits;
   logic                    underflow;
   logic [QPTR_BITS-1:0]    head_next;
   logic [QPTR_BITS-1:0]    tail_next;

   // charge and fit checks
   always_comb begin
      send_chg  = (len_ff > LEN_BITS'(min_charge_ff)) ? len_ff : LEN_BITS'(min_charge_ff);
      send_sum  = {1'b0, outstanding_ff} + (LIMIT_BITS + 1)'(send_chg);
      send_fits = (send_chg == '0) || (send_sum <= {1'b0, byte_limit_ff});
      head_chg  = q_chg_ff[head_ff];
      head_tag  = q_tag_ff[head_ff];
      head_sum  = {1'b0, outstanding_ff} + (LIMIT_BITS + 1)'(head_chg);
      head_fits = (head_chg == '0) || (head_sum <= {1'b0, byte_limit_ff});
      underflow = LIMIT_BITS'(ack_ff) > outstanding_ff;
      head_next = (head_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : head_ff + QPTR_BITS'(1);
      tail_next = (tail_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : tail_ff + QPTR_BITS'(1);
   end

   always_comb begin
      sts.is_ack      = (kind_ff == KIND_ACK);
      sts.send_fit    = (count_ff == '0) && send_fits;
      sts.queue_full  = (count_ff == QCNT_BITS'(QUEUE_DEPTH));
      sts.head_go     = (count_ff != '0) && (nres_ff < RES_BITS'(MAX_RESULTS)) && head_fits;
      sts.stg_valid   = stg_valid_ff;
      sts.out_free    = !rsp_valid_ff || rsp_ready;
      sts.queue_count = count_ff;
   end

   // next state of credit, queue and staged result
   always_comb begin
      outstanding_in = outstanding_ff;
      head_in        = head_ff;
      tail_in        = tail_ff;
      count_in       = count_ff;
      nres_in        = nres_ff;
      stg_valid_in   = stg_valid_ff;
      stg_status_in  = stg_status_ff;
      stg_tag_in     = stg_tag_ff;
      stg_chg_in     = stg_chg_ff;
      priority if (cmd.send_grant) begin
         outstanding_in = send_sum[LIMIT_BITS-1:0];
         stg_valid_in   = 1'b1;
         stg_status_in  = RES_GRANTED;
         stg_tag_in     = tag_ff;
         stg_chg_in     = send_chg;
      end else if (cmd.send_reject) begin
         stg_valid_in  = 1'b1;
         stg_status_in = RES_REJECTED;
         stg_tag_in    = tag_ff;
         stg_chg_in    = '0;
      end else if (cmd.send_queue) begin
         tail_in  = tail_next;
         count_in = count_ff + QCNT_BITS'(1);
      end else if (cmd.ack_apply) begin
         if (underflow) begin
            outstanding_in = '0;
            stg_valid_in   = 1'b1;
            stg_status_in  = RES_UNDERFLOW;
            stg_tag_in     = '0;
            stg_chg_in     = '0;
            nres_in        = RES_BITS'(1);
         end else begin
            outstanding_in = outstanding_ff - LIMIT_BITS'(ack_ff);
            stg_valid_in   = 1'b0;
            nres_in        = '0;
         end
      end else if (cmd.drain_grant) begin
         outstanding_in = head_sum[LIMIT_BITS-1:0];
         head_in        = head_next;
         count_in       = count_ff - QCNT_BITS'(1);
         nres_in        = nres_ff + RES_BITS'(1);
         stg_valid_in   = 1'b1;
         stg_status_in  = RES_GRANTED;
         stg_tag_in     = head_tag;
         stg_chg_in     = head_chg;
      end else if (cmd.emit_last) begin
         stg_valid_in = 1'b0;
      end
   end

   // output register loads the staged result once its successor is known
   always_comb begin
      rsp_load      = (cmd.drain_grant && stg_valid_ff) || cmd.emit_last;
      rsp_load_last = cmd.emit_last;
      rsp_valid_in  = rsp_load || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_limit_ff  <= BYTE_LIMIT_RESET;
         min_charge_ff  <= MIN_CHARGE_RESET;
         outstanding_ff <= '0;
         head_ff        <= '0;
         tail_ff        <= '0;
         count_ff       <= '0;
         nres_ff        <= '0;
         stg_valid_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_wen) begin
            unique case (csr_index)
               CSR_BYTE_LIMIT: byte_limit_ff <= csr_wdata[LIMIT_BITS-1:0];
               CSR_MIN_CHARGE: min_charge_ff <= csr_wdata[MINCHG_BITS-1:0];
               default: ;
            endcase
         end
         outstanding_ff <= outstanding_in;
         head_ff        <= head_in;
         tail_ff        <= tail_in;
         count_ff       <= count_in;
         nres_ff        <= nres_in;
         stg_valid_ff   <= stg_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.in_load) begin
         kind_ff <= req_kind;
         len_ff  <= req_request_length;
         tag_ff  <= req_request_tag;
         ack_ff  <= req_acked_charge;
      end
      if (cmd.send_queue) begin
         q_tag_ff[tail_ff] <= tag_ff;
         q_chg_ff[tail_ff] <= send_chg;
      end
      stg_status_ff <= stg_status_in;
      stg_tag_ff    <= stg_tag_in;
      stg_chg_ff    <= stg_chg_in;
      if (rsp_load) begin
         rsp_status_ff <= stg_status_ff;
         rsp_tag_ff    <= stg_tag_ff;
         rsp_chg_ff    <= stg_chg_ff;
         rsp_last_ff   <= rsp_load_last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_granted_tag = rsp_tag_ff;
   assign rsp_charge      = rsp_chg_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

### rtl/core/byte_credit_request_limiter_unit.sv
// ----------------------------------------------------------------------------
// byte_credit_request_limiter_unit
// Admits send requests against a budget of unacknowledged bytes, queues the
// ones that do not fit and releases them in order as acks return credit.
// ----------------------------------------------------------------------------
// Takes one item at a time. A send is latched, evaluated and handed off,
// and gives at most one result. An ack is latched and applied, then the
// wait queue is walked one grant per cycle from its head and the final
// result handed off, so released grants leave at one per cycle while
// rsp_ready stays high. A run ends after 17 results; requests that would
// still fit stay queued until the next ack. Results sit in an output
// register, so the next item is taken while the final result still waits.
// Settings are written through csr_wen, csr_index (0 byte limit, 1 minimum
// charge) and csr_wdata; the user must write them only while idle, as the block itself does not enforce it.
// ----------------------------------------------------------------------------
module byte_credit_request_limiter_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wen,
   input  logic [bcrl_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [bcrl_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_kind,
   input  logic [bcrl_pkg::LEN_BITS-1:0]        req_request_length,
   input  logic [bcrl_pkg::TAG_BITS-1:0]        req_request_tag,
   input  logic [bcrl_pkg::LEN_BITS-1:0]        req_acked_charge,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [1:0]                           rsp_status,
   output logic [bcrl_pkg::TAG_BITS-1:0]        rsp_granted_tag,
   output logic [bcrl_pkg::LEN_BITS-1:0]        rsp_charge,
   output logic                                 rsp_last
);
   import bcrl_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type sts;

   bcrl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   bcrl_dpath u_dpath (
      .clock              (clock),
      .reset              (reset),
      .csr_wen            (csr_wen),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_kind           (req_kind),
      .req_request_length (req_request_length),
      .req_request_tag    (req_request_tag),
      .req_acked_charge   (req_acked_charge),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_granted_tag    (rsp_granted_tag),
      .rsp_charge         (rsp_charge),
      .rsp_last           (rsp_last),
      .cmd                (cmd),
      .sts                (sts)
   );

`ifndef SYNTH
   a_idle_no_staged: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !sts.stg_valid)
      else $error("staged result left behind when taking a new item");

   a_one_item_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("new item taken while one is in progress");

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      sts.queue_count <= QCNT_BITS'(QUEUE_DEPTH))
      else $error("wait queue count above depth");

   a_drain_needs_slot: assert property (@(posedge clock) disable iff (reset)
      (cmd.drain_grant && sts.stg_valid) |-> sts.out_free)
      else $error("output register overwritten during drain");
`endif

endmodule

### test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench for byte_credit_request_limiter_unit. A scoreboard class keeps
// its own copy of the byte budget, the wait queue and both settings, works
// out the grants, rejects and underflow flags that each accepted item must
// cause, and checks every result in order. Directed items cover the edges of
// the budget, a full queue and the longest release run. Random phases follow
// under several settings, with random gaps on the request side and random
// stalls on the result side.
// ----------------------------------------------------------------------------
module tb_top;
   import bcrl_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int SETTLE      = 40;

   typedef struct packed {
      res_status_type          status;
      logic [TAG_BITS-1:0]     tag;
      logic [LEN_BITS-1:0]     charge;
      logic                    last;
   } grant_result_type;

   class grant_scoreboard;
      logic [LIMIT_BITS-1:0]  byte_limit;
      logic [MINCHG_BITS-1:0] min_charge;
      logic [LIMIT_BITS-1:0]  outstanding;
      logic [TAG_BITS-1:0]    slot_tag [QUEUE_DEPTH];
      logic [LEN_BITS-1:0]    slot_charge [QUEUE_DEPTH];
      logic [QPTR_BITS-1:0]   head;
      logic [QPTR_BITS-1:0]   tail;
      logic [QCNT_BITS-1:0]   count;
      grant_result_type       expected_grants[$];
      logic [LEN_BITS-1:0]    unacked_charges[$];
      int                     errors;

      function new();
         byte_limit  = BYTE_LIMIT_RESET;
         min_charge  = MIN_CHARGE_RESET;
         outstanding = '0;
         head        = '0;
         tail        = '0;
         count       = '0;
         errors      = 0;
      endfunction

      function void write_setting(logic [CSR_IDX_BITS-1:0] index,
                                  logic [CSR_DATA_BITS-1:0] value);
         if (index == CSR_BYTE_LIMIT)
            byte_limit = value[LIMIT_BITS-1:0];
         else if (index == CSR_MIN_CHARGE)
            min_charge = value[MINCHG_BITS-1:0];
      endfunction

      function bit fits(logic [LEN_BITS-1:0] chg);
         logic [LIMIT_BITS:0] sum;
         sum = {1'b0, outstanding} + (LIMIT_BITS+1)'(chg);
         return (chg == '0) || (sum <= {1'b0, byte_limit});
      endfunction

      function void add_result(res_status_type st, logic [TAG_BITS-1:0] tag,
                               logic [LEN_BITS-1:0] chg);
         grant_result_type r;
         r.status = st;
         r.tag    = tag;
         r.charge = chg;
         r.last   = 1'b0;
         expected_grants = {expected_grants, r};
      endfunction

      function void take_credit(logic [TAG_BITS-1:0] tag, logic [LEN_BITS-1:0] chg);
         outstanding = outstanding + LIMIT_BITS'(chg);
         unacked_charges = {unacked_charges, chg};
         add_result(RES_GRANTED, tag, chg);
      endfunction

      function void note_request(logic kind, logic [LEN_BITS-1:0] len,
                                 logic [TAG_BITS-1:0] tag, logic [LEN_BITS-1:0] acked);
         int            first;
         logic [LEN_BITS-1:0] chg;
         grant_result_type final_result;
         first = expected_grants.size();
         if (kind == KIND_SEND) begin
            chg = (len > LEN_BITS'(min_charge)) ? len : LEN_BITS'(min_charge);
            if (count == 0 && fits(chg)) begin
               take_credit(tag, chg);
            end else if (count >= QUEUE_DEPTH) begin
               add_result(RES_REJECTED, tag, '0);
            end else begin
               slot_tag[tail]    = tag;
               slot_charge[tail] = chg;
               tail  = (tail == QUEUE_DEPTH-1) ? '0 : tail + QPTR_BITS'(1);
               count = count + QCNT_BITS'(1);
            end
         end else begin
            if (LIMIT_BITS'(acked) > outstanding) begin
               outstanding = '0;
               unacked_charges.delete();
               add_result(RES_UNDERFLOW, '0, '0);
            end else begin
               outstanding = outstanding - LIMIT_BITS'(acked);
            end
            while (expected_grants.size() - first < MAX_RESULTS && count > 0
                   && fits(slot_charge[head])) begin
               take_credit(slot_tag[head], slot_charge[head]);
               head  = (head == QUEUE_DEPTH-1) ? '0 : head + QPTR_BITS'(1);
               count = count - QCNT_BITS'(1);
            end
         end
         if (expected_grants.size() > first) begin
            final_result = expected_grants[expected_grants.size() - 1];
            final_result.last = 1'b1;
            expected_grants[expected_grants.size() - 1] = final_result;
         end
      endfunction

      function void check_grant(logic [1:0] st, logic [TAG_BITS-1:0] tag,
                                logic [LEN_BITS-1:0] chg, logic last);
         grant_result_type e;
         if (expected_grants.size() == 0) begin
            errors++;
            $display("%0t unexpected result: status %0d tag %h charge %h last %b",
                     $time, st, tag, chg, last);
         end else begin
            e = expected_grants[0];
            expected_grants.delete(0);
            if (st !== e.status || tag !== e.tag || chg !== e.charge || last !== e.last) begin
               errors++;
               $display("%0t mismatch: expected status %0d tag %h charge %h last %b",
                        $time, e.status, e.tag, e.charge, e.last);
               $display("%0t           actual   status %0d tag %h charge %h last %b",
                        $time, st, tag, chg, last);
            end
         end
      endfunction

      function int pending();
         return expected_grants.size();
      endfunction
   endclass

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     csr_wen = 1'b0;
   logic [CSR_IDX_BITS-1:0]  csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic                     req_kind = KIND_SEND;
   logic [LEN_BITS-1:0]      req_request_length = '0;
   logic [TAG_BITS-1:0]      req_request_tag = '0;
   logic [LEN_BITS-1:0]      req_acked_charge = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [1:0]               rsp_status;
   logic [TAG_BITS-1:0]      rsp_granted_tag;
   logic [LEN_BITS-1:0]      rsp_charge;
   logic                     rsp_last;

   grant_scoreboard sb = new();
   bit              calm = 1'b0;
   int              cycle_count = 0;

   byte_credit_request_limiter_unit u_dut (
      .clock              (clock),
      .reset              (reset),
      .csr_wen            (csr_wen),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_kind           (req_kind),
      .req_request_length (req_request_length),
      .req_request_tag    (req_request_tag),
      .req_acked_charge   (req_acked_charge),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_granted_tag    (rsp_granted_tag),
      .rsp_charge         (rsp_charge),
      .rsp_last           (rsp_last)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[byte_credit_request_limiter_unit] ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_grant(rsp_status, rsp_granted_tag, rsp_charge, rsp_last);
   end

   // mostly short stalls, a few long ones
   function automatic int stall_len();
      if ($urandom_range(0, 99) < 78)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic int sender_gap();
      if (calm || $urandom_range(0, 99) < 60)
         return 0;
      return stall_len();
   endfunction

   initial begin : rsp_pacing
      int hold;
      bit level;
      hold  = 0;
      level = 1'b0;
      forever begin
         @(negedge clock);
         if (hold == 0) begin
            if (calm || $urandom_range(0, 99) < 65) begin
               level = 1'b1;
               hold  = $urandom_range(1, 24);
            end else begin
               level = 1'b0;
               hold  = stall_len();
            end
         end
         hold--;
         rsp_ready <= level;
      end
   end

   task automatic drive_item(input logic kind, input logic [LEN_BITS-1:0] len,
                             input logic [TAG_BITS-1:0] tag,
                             input logic [LEN_BITS-1:0] acked);
      int gap;
      gap = sender_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid          <= 1'b1;
      req_kind           <= kind;
      req_request_length <= len;
      req_request_tag    <= tag;
      req_acked_charge   <= acked;
      do @(posedge clock); while (!req_ready);
      sb.note_request(kind, len, tag, acked);
      @(negedge clock);
   endtask

   // unused fields of an item carry random bits
   task automatic send_req(input logic [LEN_BITS-1:0] len, input logic [TAG_BITS-1:0] tag);
      drive_item(KIND_SEND, len, tag, $urandom());
   endtask

   task automatic ack_req(input logic [LEN_BITS-1:0] acked);
      drive_item(KIND_ACK, $urandom(), $urandom_range(0, 255), acked);
   endtask

   task automatic hold_until_drained(input int settle);
      req_valid <= 1'b0;
      @(negedge clock);
      while (sb.pending() != 0) @(negedge clock);
      repeat (settle) @(negedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_BITS-1:0] index,
                            input logic [CSR_DATA_BITS-1:0] value);
      csr_wen   <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_wen   <= 1'b0;
      @(negedge clock);
      sb.write_setting(index, value);
   endtask

   function automatic logic [LEN_BITS-1:0] scale_span();
      logic [LIMIT_BITS-1:0] span;
      span = sb.byte_limit / 3;
      if (span > LIMIT_BITS'(1 << 20)) span = LIMIT_BITS'(1 << 20);
      if (span < LIMIT_BITS'(16)) span = LIMIT_BITS'(16);
      return span[LEN_BITS-1:0];
   endfunction

   function automatic logic [LEN_BITS-1:0] pick_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 20)
         return '0;
      if (r < 30 && sb.byte_limit >= (LIMIT_BITS'(1) << 34))
         return $urandom();
      return $urandom_range(0, scale_span());
   endfunction

   task automatic run_phase(input logic [LIMIT_BITS-1:0] limit,
                            input logic [MINCHG_BITS-1:0] minc,
                            input int items, input bit no_gaps);
      int r;
      int idx;
      logic [LEN_BITS-1:0] acked;
      hold_until_drained(SETTLE);
      csr_write(CSR_BYTE_LIMIT, CSR_DATA_BITS'(limit));
      csr_write(CSR_MIN_CHARGE, CSR_DATA_BITS'(minc));
      calm = no_gaps;
      for (int i = 0; i < items; i++) begin
         if ($urandom_range(0, 99) < 4)
            hold_until_drained(0);
         r = $urandom_range(0, 99);
         if (r < 58) begin
            send_req(pick_length(), $urandom_range(0, 255));
         end else if (r < 90) begin
            if (sb.unacked_charges.size() > 0) begin
               idx   = $urandom_range(0, sb.unacked_charges.size() - 1);
               acked = sb.unacked_charges[idx];
               sb.unacked_charges.delete(idx);
            end else begin
               acked = $urandom_range(0, scale_span());
            end
            ack_req(acked);
         end else if (r < 95) begin
            ack_req($urandom());
         end else begin
            ack_req($urandom_range(0, 4 * scale_span()));
         end
      end
      calm = 1'b0;
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings: minimum charge, exact fit, full queue, longest run
      send_req('0, 8'h00);
      ack_req(32'd4096);
      ack_req('0);
      send_req(32'd1048576, 8'hFF);
      for (int i = 0; i < QUEUE_DEPTH; i++)
         send_req($urandom_range(0, 4096), TAG_BITS'(i * 17));
      send_req(32'd4096, 8'h80);
      ack_req(32'hFFFF_FFFF);
      ack_req(32'd65536);

      // zero limit and zero minimum: zero charge passes, anything else waits
      hold_until_drained(SETTLE);
      csr_write(CSR_BYTE_LIMIT, '0);
      csr_write(CSR_MIN_CHARGE, '0);
      send_req('0, 8'h01);
      send_req(32'hFFFF_FFFF, 8'hF0);
      ack_req('0);

      run_phase(40'hFF_FFFF_FFFF, 17'd65536, 30, 1'b0);
      run_phase(40'd20000, 17'd1000, 34, 1'b0);
      run_phase('0, '0, 18, 1'b1);
      run_phase(LIMIT_BITS'($urandom_range(8000, 300000)),
                MINCHG_BITS'($urandom_range(0, 65536)), 38, 1'b0);
      run_phase(BYTE_LIMIT_RESET, MIN_CHARGE_RESET, 34, 1'b0);

      hold_until_drained(SETTLE);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("[byte_credit_request_limiter_unit] OK");
      else
         $display("[byte_credit_request_limiter_unit] ERROR");
      $finish;
   end

endmodule
